>>> rtl/ipv4p_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 five-tuple parser package
// Shared widths, header offsets, protocol codes and the result record.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

  // Width of the byte offset counter, which saturates at its all-ones value.
  localparam int LENGTH_BITS = 16;
  typedef logic [LENGTH_BITS-1:0] len_t;
  localparam len_t LENGTH_MAX = {LENGTH_BITS{1'b1}};

  // Frame layout
  localparam int ETH_HDR_BYTES = 14;
  localparam int IP_MIN_BYTES  = 20;
  localparam int TCP_HDR_BYTES = 20;
  localparam int UDP_HDR_BYTES = 8;
  localparam int OFS_TYPE_HI   = 12;
  localparam int OFS_TYPE_LO   = 13;
  localparam int OFS_IHL       = 14;
  localparam int OFS_PORT_MIN  = 15;
  localparam int OFS_PROTO     = 23;
  localparam int OFS_SRC_FIRST = 26;
  localparam int OFS_SRC_LAST  = 29;
  localparam int OFS_DST_FIRST = 30;
  localparam int OFS_DST_LAST  = 33;

  localparam logic [7:0] ETYPE_IPV4_HI = 8'h08;
  localparam logic [7:0] ETYPE_IPV4_LO = 8'h00;
  localparam logic [7:0] TCP_PROTO_NUM = 8'd6;
  localparam logic [7:0] UDP_PROTO_NUM = 8'd17;

  // Reported transport kind
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TCP  = 2'd1;
  localparam logic [1:0] KIND_UDP  = 2'd2;

  typedef struct packed {
    logic        packet_ok;
    logic [1:0]  protocol_kind;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] frame_length;
  } result_t;

endpackage

>>> rtl/ipv4_five_tuple_header_parser_unit.sv
// ----------------------------------------------------------------------------
// IPv4 five-tuple header parser
// Parses Ethernet/IPv4/TCP-UDP headers from a byte stream and reports
// addresses, ports, protocol and frame length once per frame.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------
//   in      | input     | in_valid_i/in_stall_o   | data_byte_i, last_byte_i
//   out     | output    | out_valid_o/out_stall_i | packet_ok_o .. frame_length_o
//
// One beat per cycle unless a last byte is held: a byte passes an input
// register, then the capture logic and, for a last byte, the result
// register. Reset clears all frame state and both valid flags. A held
// result stalls a last byte waiting behind it and the input behind that
// byte; other bytes keep flowing.
// ----------------------------------------------------------------------------
module ipv4_five_tuple_header_parser_unit
  import ipv4p_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        packet_ok_o,
  output logic [1:0]  protocol_kind_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [15:0] frame_length_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       s1_advance;
  logic       in_accept;
  logic       s1_beat;
  result_t    cap_result;
  result_t    out_result;

  // A non-last byte never waits; a last byte waits for room in the result register
  assign s1_advance = s1_valid_q && (!s1_last_q || !out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_beat    = s1_advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  ipv4p_hdr_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (s1_beat),
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .result_o    (cap_result)
  );

  ipv4p_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_beat && s1_last_q),
    .result_i    (cap_result),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign packet_ok_o      = out_result.packet_ok;
  assign protocol_kind_o  = out_result.protocol_kind;
  assign source_address_o = out_result.source_address;
  assign dest_address_o   = out_result.dest_address;
  assign source_port_o    = out_result.source_port;
  assign dest_port_o      = out_result.dest_port;
  assign frame_length_o   = out_result.frame_length;

  a_ok_has_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_ok_o |-> protocol_kind_o != KIND_NONE)
    else $error("accepted frame reported without a transport kind");

  a_reject_zeroed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !packet_ok_o |-> protocol_kind_o == KIND_NONE
      && source_address_o == '0 && dest_address_o == '0
      && source_port_o == '0 && dest_port_o == '0)
    else $error("rejected frame carries non-zero header fields");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_o && out_stall_i)
    else $error("input stalled without a blocked last byte");

  a_length_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> frame_length_o != '0)
    else $error("result reports an empty frame");

endmodule

>>> rtl/ipv4p_hdr_capture.sv
// ----------------------------------------------------------------------------
// IPv4 parser header capture
// Byte offset counter, header field capture and the frame verdict, all
// updated by one beat per cycle. Frame state clears after the last beat.
// ----------------------------------------------------------------------------
module ipv4p_hdr_capture
  import ipv4p_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output result_t    result_o
);

  len_t        offset_q, offset_d;
  logic [7:0]  type_high_q, type_high_d;
  logic        etype_good_q, etype_good_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [7:0]  proto_q, proto_d;
  logic [31:0] src_addr_q, src_addr_d;
  logic [31:0] dst_addr_q, dst_addr_d;
  logic [15:0] sport_q, sport_d;
  logic [15:0] dport_q, dport_d;

  len_t        tpos;
  len_t        tcur;
  logic [5:0]  ip_len;
  logic        hdr_good;
  logic        tcp_ok;
  logic        udp_ok;
  logic [31:0] len_wide;

  always_comb begin
    offset_d     = (offset_q == LENGTH_MAX) ? LENGTH_MAX : offset_q + len_t'(1);
    type_high_d  = type_high_q;
    etype_good_d = etype_good_q;
    ihl_d        = ihl_q;
    proto_d      = proto_q;
    src_addr_d   = src_addr_q;
    dst_addr_d   = dst_addr_q;
    sport_d      = sport_q;
    dport_d      = dport_q;

    // Transport offset from the stored IHL; stable once past the IHL byte
    tpos = len_t'(ETH_HDR_BYTES) + len_t'({ihl_q, 2'b00});

    if (offset_q == len_t'(OFS_TYPE_HI)) begin
      type_high_d = data_byte_i;
    end
    if (offset_q == len_t'(OFS_TYPE_LO)) begin
      etype_good_d = (type_high_q == ETYPE_IPV4_HI) && (data_byte_i == ETYPE_IPV4_LO);
    end
    if (offset_q == len_t'(OFS_IHL)) begin
      ihl_d = data_byte_i[3:0];
    end
    if (offset_q == len_t'(OFS_PROTO)) begin
      proto_d = data_byte_i;
    end
    if (offset_q >= len_t'(OFS_SRC_FIRST) && offset_q <= len_t'(OFS_SRC_LAST)) begin
      src_addr_d = {src_addr_q[23:0], data_byte_i};
    end
    if (offset_q >= len_t'(OFS_DST_FIRST) && offset_q <= len_t'(OFS_DST_LAST)) begin
      dst_addr_d = {dst_addr_q[23:0], data_byte_i};
    end
    if (offset_q >= len_t'(OFS_PORT_MIN)) begin
      if (offset_q == tpos || offset_q == tpos + len_t'(1)) begin
        sport_d = {sport_q[7:0], data_byte_i};
      end
      if (offset_q == tpos + len_t'(2) || offset_q == tpos + len_t'(3)) begin
        dport_d = {dport_q[7:0], data_byte_i};
      end
    end
  end

  // Verdict on the state as it stands after this beat
  always_comb begin
    ip_len   = {ihl_d, 2'b00};
    tcur     = len_t'(ETH_HDR_BYTES) + len_t'(ip_len);
    hdr_good = etype_good_d
               && (offset_d >= len_t'(ETH_HDR_BYTES + IP_MIN_BYTES))
               && (ip_len >= 6'(IP_MIN_BYTES))
               && (offset_d >= tcur);
    tcp_ok   = hdr_good && (proto_d == TCP_PROTO_NUM)
               && (offset_d >= tcur + len_t'(TCP_HDR_BYTES));
    udp_ok   = hdr_good && (proto_d == UDP_PROTO_NUM)
               && (offset_d >= tcur + len_t'(UDP_HDR_BYTES));
    len_wide = 32'(offset_d);

    result_o                = '0;
    result_o.packet_ok      = tcp_ok || udp_ok;
    result_o.protocol_kind  = tcp_ok ? KIND_TCP : (udp_ok ? KIND_UDP : KIND_NONE);
    result_o.frame_length   = len_wide[15:0];
    if (tcp_ok || udp_ok) begin
      result_o.source_address = src_addr_d;
      result_o.dest_address   = dst_addr_d;
      result_o.source_port    = sport_d;
      result_o.dest_port      = dport_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= '0;
      type_high_q  <= '0;
      etype_good_q <= 1'b0;
      ihl_q        <= '0;
      proto_q      <= '0;
      src_addr_q   <= '0;
      dst_addr_q   <= '0;
      sport_q      <= '0;
      dport_q      <= '0;
    end else if (beat_i) begin
      if (last_byte_i) begin
        // drop frame state, ready for the next frame
        offset_q     <= '0;
        type_high_q  <= '0;
        etype_good_q <= 1'b0;
        ihl_q        <= '0;
        proto_q      <= '0;
        src_addr_q   <= '0;
        dst_addr_q   <= '0;
        sport_q      <= '0;
        dport_q      <= '0;
      end else begin
        offset_q     <= offset_d;
        type_high_q  <= type_high_d;
        etype_good_q <= etype_good_d;
        ihl_q        <= ihl_d;
        proto_q      <= proto_d;
        src_addr_q   <= src_addr_d;
        dst_addr_q   <= dst_addr_d;
        sport_q      <= sport_d;
        dport_q      <= dport_d;
      end
    end
  end

endmodule

>>> rtl/ipv4p_result_reg.sv
// ----------------------------------------------------------------------------
// IPv4 parser result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ipv4p_result_reg
  import ipv4p_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

>>> test/ipv4_five_tuple_header_parser_unit_test.sv
// ----------------------------------------------------------------------------
// IPv4 five-tuple header parser testbench
// Streams Ethernet frames byte by byte into the parser. The frames are
// mostly well formed, with some truncated or malformed ones mixed in.
// A scoreboard predicts each per-frame result from the accepted
// bytes and compares every field of each result the block delivers.
// Random idle bursts fall on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipv4_five_tuple_header_parser_unit_test
  import ipv4p_pkg::*;
;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1800;
  localparam int MIN_FRAMES   = 24;
  localparam int REPORT_MAX   = 10;

  class five_tuple_scoreboard;
    len_t        offset;
    logic [7:0]  type_hi;
    bit          etype_ok;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
    result_t     expected_tuples[$];
    int          mismatches;
    int          strays;

    function new();
      mismatches = 0;
      strays = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      offset = '0;
      type_hi = '0;
      etype_ok = 1'b0;
      ihl = '0;
      proto = '0;
      src_addr = '0;
      dst_addr = '0;
      sport = '0;
      dport = '0;
    endfunction

    function int pending();
      return expected_tuples.size();
    endfunction

    function int failures();
      return mismatches + strays + expected_tuples.size();
    endfunction

    function string show(result_t r);
      return $sformatf("ok=%0d kind=%0d src=%h dst=%h sport=%h dport=%h len=%0d",
                       r.packet_ok, r.protocol_kind, r.source_address,
                       r.dest_address, r.source_port, r.dest_port, r.frame_length);
    endfunction

    // Advance the frame state by one accepted byte; queue a result on the last.
    function void note_beat(logic [7:0] b, logic last);
      longint  idx;
      longint  tpos;
      longint  flen;
      longint  tcur;
      len_t    nlen;
      result_t r;
      idx  = offset;
      tpos = ETH_HDR_BYTES + 4 * longint'(ihl);
      nlen = (offset == LENGTH_MAX) ? LENGTH_MAX : offset + 1'b1;
      if (idx == OFS_TYPE_HI) type_hi = b;
      if (idx == OFS_TYPE_LO) etype_ok = (type_hi == ETYPE_IPV4_HI) && (b == ETYPE_IPV4_LO);
      if (idx == OFS_IHL) ihl = b[3:0];
      if (idx == OFS_PROTO) proto = b;
      if (idx >= OFS_SRC_FIRST && idx <= OFS_SRC_LAST) src_addr = {src_addr[23:0], b};
      if (idx >= OFS_DST_FIRST && idx <= OFS_DST_LAST) dst_addr = {dst_addr[23:0], b};
      if (idx >= OFS_PORT_MIN) begin
        if (idx == tpos || idx == tpos + 1) sport = {sport[7:0], b};
        if (idx == tpos + 2 || idx == tpos + 3) dport = {dport[7:0], b};
      end
      offset = nlen;
      if (!last) return;

      flen = nlen;
      tcur = ETH_HDR_BYTES + 4 * longint'(ihl);
      r = '0;
      if (flen >= ETH_HDR_BYTES && etype_ok && flen >= ETH_HDR_BYTES + IP_MIN_BYTES &&
          4 * longint'(ihl) >= IP_MIN_BYTES && flen >= tcur) begin
        if (proto == TCP_PROTO_NUM && flen >= tcur + TCP_HDR_BYTES) begin
          r.packet_ok = 1'b1;
          r.protocol_kind = KIND_TCP;
        end else if (proto == UDP_PROTO_NUM && flen >= tcur + UDP_HDR_BYTES) begin
          r.packet_ok = 1'b1;
          r.protocol_kind = KIND_UDP;
        end
      end
      if (r.packet_ok) begin
        r.source_address = src_addr;
        r.dest_address = dst_addr;
        r.source_port = sport;
        r.dest_port = dport;
      end
      r.frame_length = nlen[15:0];
      expected_tuples.push_back(r);
      clear_frame();
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_tuples.size() == 0) begin
        strays++;
        if (mismatches + strays <= REPORT_MAX)
          $display("%0t: unexpected result: %s", $realtime, show(got));
        return;
      end
      exp = expected_tuples.pop_front();
      if (got.packet_ok !== exp.packet_ok || got.protocol_kind !== exp.protocol_kind ||
          got.source_address !== exp.source_address ||
          got.dest_address !== exp.dest_address || got.source_port !== exp.source_port ||
          got.dest_port !== exp.dest_port || got.frame_length !== exp.frame_length) begin
        mismatches++;
        if (mismatches + strays <= REPORT_MAX) begin
          $display("%0t: result differs", $realtime);
          $display("  expected %s", show(exp));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        packet_ok_o;
  logic [1:0]  protocol_kind_o;
  logic [31:0] source_address_o;
  logic [31:0] dest_address_o;
  logic [15:0] source_port_o;
  logic [15:0] dest_port_o;
  logic [15:0] frame_length_o;

  five_tuple_scoreboard sb = new();

  logic [7:0] frame_bytes[$];
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         bytes_sent = 0;
  int         frames_sent = 0;
  int         idle_cycles = 0;

  ipv4_five_tuple_header_parser_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .packet_ok_o     (packet_ok_o),
    .protocol_kind_o (protocol_kind_o),
    .source_address_o(source_address_o),
    .dest_address_o  (dest_address_o),
    .source_port_o   (source_port_o),
    .dest_port_o     (dest_port_o),
    .frame_length_o  (frame_length_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: stall in random bursts while stall_pct is non-zero.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_beat(data_byte_i, last_byte_i);
      if (out_valid_o && !out_stall_i)
        sb.check_result('{packet_ok_o, protocol_kind_o, source_address_o, dest_address_o,
                          source_port_o, dest_port_o, frame_length_o});
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Drive one byte from a falling edge and hold it until the beat is taken.
  task automatic send_beat(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    bytes_sent += frame_bytes.size();
    frames_sent++;
  endtask

  // Build a frame; clean ones are full IPv4 TCP or UDP with IHL of five.
  task automatic build_frame(input bit clean, input int extra);
    int          ihl;
    int          ipb;
    int          thb;
    int          total;
    int          keep;
    int          pick;
    logic [7:0]  proto;
    logic [15:0] etype;
    bit          trunc;
    etype = {ETYPE_IPV4_HI, ETYPE_IPV4_LO};
    ihl   = 5;
    proto = $urandom_range(0, 1) ? TCP_PROTO_NUM : UDP_PROTO_NUM;
    trunc = 1'b0;
    if (!clean) begin
      case ($urandom_range(0, 9))
        0: etype = 16'($urandom);
        1: etype = {ETYPE_IPV4_HI, 8'($urandom_range(1, 255))};
        2: etype = {8'($urandom), ETYPE_IPV4_LO};
        default: ;
      endcase
      pick = $urandom_range(0, 19);
      if (pick < 3) ihl = $urandom_range(0, 4);
      else if (pick < 7) ihl = $urandom_range(6, 15);
      if ($urandom_range(0, 6) == 0) proto = 8'($urandom);
      trunc = ($urandom_range(0, 3) == 0);
    end
    ipb = (ihl * 4 < IP_MIN_BYTES) ? IP_MIN_BYTES : ihl * 4;
    thb = (proto == TCP_PROTO_NUM) ? TCP_HDR_BYTES :
          (proto == UDP_PROTO_NUM) ? UDP_HDR_BYTES : $urandom_range(0, 20);
    total = ETH_HDR_BYTES + ipb + thb + $urandom_range(0, 12) + extra;
    frame_bytes.delete();
    repeat (total) frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes[OFS_TYPE_HI] = etype[15:8];
    frame_bytes[OFS_TYPE_LO] = etype[7:0];
    frame_bytes[OFS_IHL]     = {4'($urandom), 4'(ihl)};
    frame_bytes[OFS_PROTO]   = proto;
    if (trunc) begin
      keep = $urandom_range(1, total);
      while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Runt frames: a lone last byte, one short of the Ethernet header, and
    // an Ethernet header alone carrying the IPv4 type.
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes.delete();
    repeat (13) frame_bytes.push_back(8'h00);
    send_frame();
    frame_bytes.delete();
    repeat (ETH_HDR_BYTES) frame_bytes.push_back(8'hFF);
    frame_bytes[OFS_TYPE_HI] = ETYPE_IPV4_HI;
    frame_bytes[OFS_TYPE_LO] = ETYPE_IPV4_LO;
    send_frame();

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES || frames_sent < MIN_FRAMES) begin
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 8;
        default: gap_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 5;
        default: stall_pct = 25;
      endcase
      build_frame($urandom_range(0, 2) == 0, 0);
      send_frame();
    end

    // Quiet tail: back-to-back frames with no idling on either side.
    gap_pct   = 0;
    stall_pct = 0;
    build_frame(1'b1, 0);
    send_frame();
    build_frame(1'b1, 0);
    send_frame();
    build_frame(1'b1, 0);
    send_frame();
    build_frame(1'b0, 0);
    send_frame();
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failures() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ipv4p_pkg.sv
rtl/ipv4p_hdr_capture.sv
rtl/ipv4p_result_reg.sv
rtl/ipv4_five_tuple_header_parser_unit.sv
test/ipv4_five_tuple_header_parser_unit_test.sv
